// ===== src/box_filter_nms_assert.svh =====
// Assertion macros for the RTL file that checks itself (box_filter_nms).
// Each macro expects clk and rst_n in scope.
`ifndef BOX_FILTER_NMS_ASSERT_SVH
`define BOX_FILTER_NMS_ASSERT_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication.
`define BFN_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication.
`define BFN_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define BFN_ASSERT_IMPLY(lbl, ante, cons, msg)
`define BFN_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ===== src/bfn_pkg.sv =====
package bfn_pkg;

  // Port widths
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int IN_DATA_W  = 80;
  localparam int OUT_DATA_W = 64;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CONF = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OVL  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_IMW  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_IMH  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SCL  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_PADL = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_PADT = 3'd6;

  // Register reset values
  localparam logic [15:0] CONF_RST = 16'd16384;
  localparam logic [15:0] OVL_RST  = 16'd29491;
  localparam logic [12:0] IMG_RST  = 13'd640;
  localparam logic [15:0] SCL_RST  = 16'd16384;

  // Highest quotient bit of the edge divider; larger quotients saturate
  localparam logic [3:0] DIV_TOP_BIT = 4'd12;
  localparam logic [12:0] DIM_MAX = 13'd4096;

  // One stored box; x sits in the lowest bits, same layout as out_tdata
  typedef struct packed {
    logic [15:0] score;
    logic [11:0] h;
    logic [11:0] w;
    logic [11:0] y;
    logic [11:0] x;
  } box_t;

  typedef enum logic [1:0] {
    RD_TAIL,
    RD_KM1,
    RD_I,
    RD_J
  } rd_sel_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_CHECK,
    ST_MAP_GO,
    ST_MAP_RUN,
    ST_INS_CHK,
    ST_INS_CHKW,
    ST_INS_START,
    ST_INS_WALK,
    ST_INS_CMP,
    ST_POST,
    ST_FRAME,
    ST_NMS_I,
    ST_NMS_LI,
    ST_NMS_AI,
    ST_NMS_J,
    ST_P1,
    ST_P2,
    ST_P3,
    ST_P4,
    ST_P5,
    ST_E_GO,
    ST_E_SCAN,
    ST_E_DATA,
    ST_E_FIN,
    ST_E_NONE
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic    load_item;
    logic    map_start;
    logic    map_run;
    logic    rd_en;
    rd_sel_t rd_sel;
    logic    wr_en;
    logic    wr_new;
    logic    ins_trim;
    logic    k_load;
    logic    k_dec;
    logic    cnt_inc;
    logic    i_clear;
    logic    i_inc;
    logic    j_load;
    logic    j_inc;
    logic    latch_i;
    logic    mark_set;
    logic    pend_clear;
    logic    emit_push;
    logic    emit_fin;
    logic    emit_none;
    logic    frame_clear;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic pass;
    logic last;
    logic map_done;
    logic full;
    logic tail_ge;
    logic rd_ge_new;
    logic k_zero;
    logic cnt_zero;
    logic i_end;
    logic j_end;
    logic mark_i;
    logic mark_j;
    logic hit;
    logic pend_v;
    logic out_free;
  } sts_t;

endpackage

// ===== src/bfn_ram.sv =====
module bfn_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic                                     re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // Registered read, held while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== src/bfn_datapath.sv =====
module bfn_datapath #(
  parameter int MAX_CANDIDATES = 64
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [bfn_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bfn_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic [bfn_pkg::IN_DATA_W-1:0]   in_tdata,
  input  logic                            in_tlast,
  input  bfn_pkg::cmd_t                   cmd,
  output bfn_pkg::sts_t                   sts,
  input  logic                            out_tready,
  output logic                            out_tvalid,
  output logic [bfn_pkg::OUT_DATA_W-1:0]  out_tdata,
  output logic                            out_tlast,
  output logic                            out_tuser
);

  import bfn_pkg::*;

  localparam int AW = (MAX_CANDIDATES > 1) ? $clog2(MAX_CANDIDATES) : 1;
  localparam int CW = $clog2(MAX_CANDIDATES + 1);

  // Configuration registers
  logic [15:0] conf_r, ovl_r, scl_r;
  logic [12:0] imw_r, imh_r;
  logic [11:0] padl_r, padt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      conf_r <= CONF_RST;
      ovl_r  <= OVL_RST;
      imw_r  <= IMG_RST;
      imh_r  <= IMG_RST;
      scl_r  <= SCL_RST;
      padl_r <= '0;
      padt_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CONF: conf_r <= cfg_data;
        REG_OVL:  ovl_r  <= cfg_data;
        REG_IMW:  imw_r  <= cfg_data[12:0];
        REG_IMH:  imh_r  <= cfg_data[12:0];
        REG_SCL:  scl_r  <= cfg_data;
        REG_PADL: padl_r <= cfg_data[11:0];
        REG_PADT: padt_r <= cfg_data[11:0];
        default: ;
      endcase
    end
  end

  // Input word
  logic [15:0] cx_r, cy_r, sw_r, sh_r, sc_r;
  logic        last_r;

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      cx_r   <= in_tdata[15:0];
      cy_r   <= in_tdata[31:16];
      sw_r   <= in_tdata[47:32];
      sh_r   <= in_tdata[63:48];
      sc_r   <= in_tdata[79:64];
      last_r <= in_tlast;
    end
  end

  // Edge mapping: one shared restoring divider, one quotient bit a cycle
  logic [1:0]  edge_r;
  logic [3:0]  bit_r;
  logic        ld_r, done_r;
  logic [27:0] rem_r, rem_nxt, dsh;
  logic [12:0] q_r, q_nxt;
  logic [11:0] ev_r [4];

  logic        selx, lo, neg, sat, zero;
  logic [15:0] c_sel, sz_sel, sdiv;
  logic [11:0] pad_sel, hi, edge_val;
  logic [12:0] dim_sel, dimc, hi_full;
  logic signed [19:0] n_s, base_s;
  logic [19:0] mag_full;
  logic [18:0] mag;
  logic [28:0] diff;

  assign selx    = ~edge_r[0];
  assign lo      = ~edge_r[1];
  assign c_sel   = selx ? cx_r : cy_r;
  assign sz_sel  = selx ? sw_r : sh_r;
  assign pad_sel = selx ? padl_r : padt_r;
  assign dim_sel = selx ? imw_r : imh_r;
  assign base_s  = $signed({3'b0, c_sel, 1'b0}) - $signed({3'b0, pad_sel, 5'b0});
  assign n_s     = lo ? (base_s - $signed({4'b0, sz_sel})) : (base_s + $signed({4'b0, sz_sel}));
  assign neg     = n_s[19];
  assign mag_full = neg ? (~n_s + 20'd1) : n_s;
  assign mag     = mag_full[18:0];
  assign sdiv    = (scl_r == 16'd0) ? 16'd1 : scl_r;
  assign sat     = {1'b0, mag} >= {sdiv, 4'b0};
  assign dimc    = (dim_sel > DIM_MAX) ? DIM_MAX : dim_sel;
  assign hi_full = dimc - 13'd1;
  assign hi      = hi_full[11:0];
  assign zero    = neg || (dim_sel == 13'd0);
  assign dsh     = {12'b0, sdiv} << bit_r;
  assign diff    = {1'b0, rem_r} - {1'b0, dsh};
  assign rem_nxt = diff[28] ? rem_r : diff[27:0];

  always_comb begin
    q_nxt = q_r;
    q_nxt[bit_r] = ~diff[28];
  end

  assign edge_val = zero ? 12'd0 : ((sat || (q_nxt > {1'b0, hi})) ? hi : q_nxt[11:0]);

  // Divider sequencing
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      edge_r <= '0;
      bit_r  <= '0;
      ld_r   <= 1'b0;
      done_r <= 1'b0;
    end else if (cmd.map_start) begin
      edge_r <= '0;
      ld_r   <= 1'b1;
      done_r <= 1'b0;
    end else if (cmd.map_run && !done_r) begin
      if (ld_r) begin
        ld_r  <= 1'b0;
        bit_r <= DIV_TOP_BIT;
      end else if (bit_r == 4'd0) begin
        if (edge_r == 2'd3) begin
          done_r <= 1'b1;
        end else begin
          edge_r <= edge_r + 2'd1;
          ld_r   <= 1'b1;
        end
      end else begin
        bit_r <= bit_r - 4'd1;
      end
    end
  end

  // Divider payload
  always_ff @(posedge clk) begin
    if (cmd.map_run && !done_r) begin
      if (ld_r) begin
        rem_r <= {mag, 9'b0};
        q_r   <= '0;
      end else begin
        rem_r <= rem_nxt;
        q_r   <= q_nxt;
        if (bit_r == 4'd0) begin
          ev_r[edge_r] <= edge_val;
        end
      end
    end
  end

  // New box from the four mapped edges
  box_t nb;
  assign nb.x     = ev_r[0];
  assign nb.y     = ev_r[1];
  assign nb.w     = ev_r[2] - ev_r[0];
  assign nb.h     = ev_r[3] - ev_r[1];
  assign nb.score = sc_r;

  // Frame counters and suppression marks
  logic [CW-1:0] count_r, k_r, i_r, j_r, km1;
  logic [MAX_CANDIDATES-1:0] marks_r;

  assign km1 = k_r - CW'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      k_r     <= '0;
      i_r     <= '0;
      j_r     <= '0;
      marks_r <= '0;
    end else begin
      if (cmd.frame_clear) begin
        count_r <= '0;
        marks_r <= '0;
      end else begin
        if (cmd.ins_trim) begin
          count_r <= CW'(MAX_CANDIDATES - 1);
        end else if (cmd.cnt_inc) begin
          count_r <= count_r + CW'(1);
        end
        if (cmd.mark_set) begin
          marks_r[j_r[AW-1:0]] <= 1'b1;
        end
      end
      if (cmd.k_load) begin
        k_r <= count_r;
      end else if (cmd.k_dec) begin
        k_r <= km1;
      end
      if (cmd.i_clear) begin
        i_r <= '0;
      end else if (cmd.i_inc) begin
        i_r <= i_r + CW'(1);
      end
      if (cmd.j_load) begin
        j_r <= i_r + CW'(1);
      end else if (cmd.j_inc) begin
        j_r <= j_r + CW'(1);
      end
    end
  end

  // Candidate memory
  logic [AW-1:0] raddr;
  logic [OUT_DATA_W-1:0] ram_rdata;
  box_t rbox, wbox;

  always_comb begin
    unique case (cmd.rd_sel)
      RD_TAIL: raddr = AW'(MAX_CANDIDATES - 1);
      RD_KM1:  raddr = km1[AW-1:0];
      RD_I:    raddr = i_r[AW-1:0];
      RD_J:    raddr = j_r[AW-1:0];
      default: raddr = '0;
    endcase
  end

  assign rbox = ram_rdata;
  assign wbox = cmd.wr_new ? nb : rbox;

  bfn_ram #(
    .WIDTH (OUT_DATA_W),
    .DEPTH (MAX_CANDIDATES)
  ) u_store (
    .clk   (clk),
    .we    (cmd.wr_en),
    .waddr (k_r[AW-1:0]),
    .wdata (wbox),
    .re    (cmd.rd_en),
    .raddr (raddr),
    .rdata (ram_rdata)
  );

  // Overlap pipeline, box i held, box j from the memory read
  box_t bi_r;
  logic [23:0] ai_r, aj_r;
  logic [12:0] bx2, rx2, by2, ry2, xx1, xx2, yy1, yy2, iw, ih;
  logic [12:0] iw_r, ih_r;
  logic [11:0] jw_r, jh_r;
  logic [25:0] inter_r, inter2_r;
  logic [26:0] uni_r;
  logic        upos_r;
  logic [41:0] prod_r;

  assign bx2 = {1'b0, bi_r.x} + {1'b0, bi_r.w};
  assign rx2 = {1'b0, rbox.x} + {1'b0, rbox.w};
  assign by2 = {1'b0, bi_r.y} + {1'b0, bi_r.h};
  assign ry2 = {1'b0, rbox.y} + {1'b0, rbox.h};
  assign xx1 = (bi_r.x > rbox.x) ? {1'b0, bi_r.x} : {1'b0, rbox.x};
  assign yy1 = (bi_r.y > rbox.y) ? {1'b0, bi_r.y} : {1'b0, rbox.y};
  assign xx2 = (bx2 < rx2) ? bx2 : rx2;
  assign yy2 = (by2 < ry2) ? by2 : ry2;
  assign iw  = (xx2 > xx1) ? (xx2 - xx1) : 13'd0;
  assign ih  = (yy2 > yy1) ? (yy2 - yy1) : 13'd0;

  always_ff @(posedge clk) begin
    if (cmd.latch_i) begin
      bi_r <= rbox;
    end
    ai_r     <= bi_r.w * bi_r.h;
    iw_r     <= iw;
    ih_r     <= ih;
    jw_r     <= rbox.w;
    jh_r     <= rbox.h;
    inter_r  <= iw_r * ih_r;
    aj_r     <= jw_r * jh_r;
    uni_r    <= {3'b0, ai_r} + {3'b0, aj_r} - {1'b0, inter_r};
    upos_r   <= !uni_r[26] && (uni_r != 27'd0);
    prod_r   <= {26'b0, ovl_r} * {16'b0, uni_r[25:0]};
    inter2_r <= inter_r;
  end

  // Result register and one pending kept box for last marking
  logic out_v_r, out_l_r, out_n_r, pend_v_r;
  box_t out_d_r, pend_d_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      pend_v_r <= 1'b0;
    end else begin
      if (cmd.emit_none || cmd.emit_fin || (cmd.emit_push && pend_v_r)) begin
        out_v_r <= 1'b1;
      end else if (out_tready) begin
        out_v_r <= 1'b0;
      end
      if (cmd.emit_push) begin
        pend_v_r <= 1'b1;
      end else if (cmd.emit_fin || cmd.pend_clear) begin
        pend_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_none) begin
      out_d_r <= '0;
      out_l_r <= 1'b1;
      out_n_r <= 1'b1;
    end else if (cmd.emit_fin || (cmd.emit_push && pend_v_r)) begin
      out_d_r <= pend_d_r;
      out_l_r <= cmd.emit_fin;
      out_n_r <= 1'b0;
    end
    if (cmd.emit_push) begin
      pend_d_r <= rbox;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_d_r;
  assign out_tlast  = out_l_r;
  assign out_tuser  = out_n_r;

  // Status to the controller
  assign sts.pass      = sc_r >= conf_r;
  assign sts.last      = last_r;
  assign sts.map_done  = done_r;
  assign sts.full      = count_r == CW'(MAX_CANDIDATES);
  assign sts.tail_ge   = sc_r <= rbox.score;
  assign sts.rd_ge_new = rbox.score >= sc_r;
  assign sts.k_zero    = k_r == '0;
  assign sts.cnt_zero  = count_r == '0;
  assign sts.i_end     = i_r == count_r;
  assign sts.j_end     = j_r == count_r;
  assign sts.mark_i    = marks_r[i_r[AW-1:0]];
  assign sts.mark_j    = marks_r[j_r[AW-1:0]];
  assign sts.hit       = upos_r && ({inter2_r, 16'b0} > prod_r);
  assign sts.pend_v    = pend_v_r;
  assign sts.out_free  = !out_v_r || out_tready;

endmodule

// ===== src/bfn_ctrl.sv =====
module bfn_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  bfn_pkg::sts_t sts,
  output bfn_pkg::cmd_t cmd
);

  import bfn_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:      if (in_tvalid) state_nxt = ST_CHECK;
      ST_CHECK:     state_nxt = sts.pass ? ST_MAP_GO : ST_POST;
      ST_MAP_GO:    state_nxt = ST_MAP_RUN;
      ST_MAP_RUN:   if (sts.map_done) state_nxt = ST_INS_CHK;
      ST_INS_CHK:   state_nxt = sts.full ? ST_INS_CHKW : ST_INS_START;
      ST_INS_CHKW:  state_nxt = sts.tail_ge ? ST_POST : ST_INS_START;
      ST_INS_START: state_nxt = ST_INS_WALK;
      ST_INS_WALK:  state_nxt = sts.k_zero ? ST_POST : ST_INS_CMP;
      ST_INS_CMP:   state_nxt = sts.rd_ge_new ? ST_POST : ST_INS_WALK;
      ST_POST:      state_nxt = sts.last ? ST_FRAME : ST_IDLE;
      ST_FRAME:     state_nxt = sts.cnt_zero ? ST_E_NONE : ST_NMS_I;
      ST_NMS_I: begin
        priority if (sts.i_end) state_nxt = ST_E_GO;
        else if (sts.mark_i)    state_nxt = ST_NMS_I;
        else                    state_nxt = ST_NMS_LI;
      end
      ST_NMS_LI:    state_nxt = ST_NMS_AI;
      ST_NMS_AI:    state_nxt = ST_NMS_J;
      ST_NMS_J: begin
        priority if (sts.j_end) state_nxt = ST_NMS_I;
        else if (sts.mark_j)    state_nxt = ST_NMS_J;
        else                    state_nxt = ST_P1;
      end
      ST_P1:        state_nxt = ST_P2;
      ST_P2:        state_nxt = ST_P3;
      ST_P3:        state_nxt = ST_P4;
      ST_P4:        state_nxt = ST_P5;
      ST_P5:        state_nxt = ST_NMS_J;
      ST_E_GO:      state_nxt = ST_E_SCAN;
      ST_E_SCAN: begin
        priority if (sts.i_end) state_nxt = ST_E_FIN;
        else if (sts.mark_i)    state_nxt = ST_E_SCAN;
        else                    state_nxt = ST_E_DATA;
      end
      ST_E_DATA:    if (!sts.pend_v || sts.out_free) state_nxt = ST_E_SCAN;
      ST_E_FIN:     if (sts.out_free) state_nxt = ST_IDLE;
      ST_E_NONE:    if (sts.out_free) state_nxt = ST_IDLE;
      default:      state_nxt = ST_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    cmd = '0;
    cmd.rd_sel = RD_I;
    unique case (state_r)
      ST_IDLE:      cmd.load_item = in_tvalid;
      ST_MAP_GO:    cmd.map_start = 1'b1;
      ST_MAP_RUN:   cmd.map_run = 1'b1;
      ST_INS_CHK: begin
        cmd.rd_en  = sts.full;
        cmd.rd_sel = RD_TAIL;
      end
      ST_INS_CHKW:  cmd.ins_trim = !sts.tail_ge;
      ST_INS_START: cmd.k_load = 1'b1;
      ST_INS_WALK: begin
        cmd.rd_sel = RD_KM1;
        if (sts.k_zero) begin
          cmd.wr_en   = 1'b1;
          cmd.wr_new  = 1'b1;
          cmd.cnt_inc = 1'b1;
        end else begin
          cmd.rd_en = 1'b1;
        end
      end
      ST_INS_CMP: begin
        cmd.wr_en = 1'b1;
        if (sts.rd_ge_new) begin
          cmd.wr_new  = 1'b1;
          cmd.cnt_inc = 1'b1;
        end else begin
          cmd.k_dec = 1'b1;
        end
      end
      ST_FRAME:     cmd.i_clear = 1'b1;
      ST_NMS_I: begin
        if (!sts.i_end) begin
          cmd.i_inc = sts.mark_i;
          cmd.rd_en = !sts.mark_i;
        end
      end
      ST_NMS_LI: begin
        cmd.latch_i = 1'b1;
        cmd.j_load  = 1'b1;
      end
      ST_NMS_J: begin
        cmd.rd_sel = RD_J;
        priority if (sts.j_end) cmd.i_inc = 1'b1;
        else if (sts.mark_j)    cmd.j_inc = 1'b1;
        else                    cmd.rd_en = 1'b1;
      end
      ST_P5: begin
        cmd.mark_set = sts.hit;
        cmd.j_inc    = 1'b1;
      end
      ST_E_GO: begin
        cmd.i_clear    = 1'b1;
        cmd.pend_clear = 1'b1;
      end
      ST_E_SCAN: begin
        if (!sts.i_end) begin
          cmd.i_inc = sts.mark_i;
          cmd.rd_en = !sts.mark_i;
        end
      end
      ST_E_DATA: begin
        if (!sts.pend_v || sts.out_free) begin
          cmd.emit_push = 1'b1;
          cmd.i_inc     = 1'b1;
        end
      end
      ST_E_FIN: begin
        cmd.emit_fin    = sts.out_free;
        cmd.frame_clear = sts.out_free;
      end
      ST_E_NONE: begin
        cmd.emit_none   = sts.out_free;
        cmd.frame_clear = sts.out_free;
      end
      default: ;
    endcase
  end

  assign in_tready = (state_r == ST_IDLE);

endmodule

// ===== src/box_filter_nms.sv =====
// Box filter and greedy NMS. Each input word is one detector box; boxes under the
// confidence threshold are dropped, the rest are mapped to image pixels and kept
// sorted by score in a single-port-read, single-port-write memory of MAX_CANDIDATES
// entries. A kept box has each of its edges mapped in turn by one shared divider, then
// is placed by a sorted insert that moves lower-scored stored entries down one place.
// The word with tlast starts suppression: each box pair tested takes a memory read
// then a four-stage overlap pipeline, and then the kept results are emitted in order.
// No word is taken during that work. A frame with no kept box yields one result
// with tuser set and all data zero. Config writes are taken in any cycle.
module box_filter_nms #(
  parameter int MAX_CANDIDATES = 64
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // cfg write channel
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [bfn_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bfn_pkg::CFG_DATA_W-1:0]  cfg_data,
  // box stream in
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // center_x, center_y, size_w, size_h, box_score (16b each)
  input  logic [bfn_pkg::IN_DATA_W-1:0]   in_tdata,
  input  logic                            in_tlast,
  // result stream out
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // left, top, box_width, box_height (12b each), kept_score (16b)
  output logic [bfn_pkg::OUT_DATA_W-1:0]  out_tdata,
  output logic                            out_tlast,
  // none_found
  output logic                            out_tuser
);

  import bfn_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  bfn_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  bfn_datapath #(
    .MAX_CANDIDATES (MAX_CANDIDATES)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_valid && cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .cmd        (cmd),
    .sts        (sts),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

`include "box_filter_nms_assert.svh"

  `BFN_ASSERT_NEXT(a_one_word, in_tvalid && in_tready, !in_tready, "second word taken while busy")
  `BFN_ASSERT_IMPLY(a_none_form, out_tvalid && out_tuser, out_tlast && (out_tdata == '0), "bad empty-frame result")
  `BFN_ASSERT_IMPLY(a_emit_idle, cmd.emit_push || cmd.emit_fin, !in_tready, "result emitted while idle")

endmodule

// ===== bench/testbench.sv =====
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import bfn_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_NONE = 3'd7;  // unused index, write is ignored
  localparam int STORE_DEPTH = 64;
  localparam longint CYCLE_LIMIT = 2000000;

  // Expected frame results: mirrors the box store and greedy suppression
  class nms_scoreboard;
    typedef struct {
      box_t b;
      bit   lst;
      bit   none;
    } result_t;

    logic [15:0] conf, ovl, scale;
    logic [12:0] imw, imh;
    logic [11:0] padl, padt;
    box_t        store[STORE_DEPTH];
    int          cnt;
    result_t     expq[$];
    int          errors, results, frames, boxes;

    function new();
      conf = CONF_RST;
      ovl = OVL_RST;
      imw = IMG_RST;
      imh = IMG_RST;
      scale = SCL_RST;
      padl = '0;
      padt = '0;
      cnt = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] v);
      case (idx)
        REG_CONF: conf = v;
        REG_OVL:  ovl = v;
        REG_IMW:  imw = v[12:0];
        REG_IMH:  imh = v[12:0];
        REG_SCL:  scale = v;
        REG_PADL: padl = v[11:0];
        REG_PADT: padt = v[11:0];
        default: ;
      endcase
    endfunction

    // Edge in 1/32 pixel to image pixel, truncated toward zero and clamped
    function longint map_edge(longint n, longint dim);
      longint s, mag, q, v;
      s = (scale == 0) ? 1 : scale;
      mag = (n < 0) ? -n : n;
      q = (mag * 512) / s;
      v = (n < 0) ? -q : q;
      if (dim > 4096) dim = 4096;
      if (v > dim - 1) v = dim - 1;
      if (v < 0) v = 0;
      return v;
    endfunction

    function bit overlaps(box_t a, box_t b);
      longint xx1, yy1, xx2, yy2, iw, ih, inter, uni;
      xx1 = (a.x > b.x) ? a.x : b.x;
      yy1 = (a.y > b.y) ? a.y : b.y;
      xx2 = (longint'(a.x) + a.w < longint'(b.x) + b.w) ? longint'(a.x) + a.w
                                                         : longint'(b.x) + b.w;
      yy2 = (longint'(a.y) + a.h < longint'(b.y) + b.h) ? longint'(a.y) + a.h
                                                         : longint'(b.y) + b.h;
      iw = (xx2 > xx1) ? xx2 - xx1 : 0;
      ih = (yy2 > yy1) ? yy2 - yy1 : 0;
      inter = iw * ih;
      uni = longint'(a.w) * a.h + longint'(b.w) * b.h - inter;
      if (uni <= 0) return 0;
      return inter * 65536 > longint'(ovl) * uni;
    endfunction

    // Note one accepted box word; on the frame end, queue its results
    function void note_box(logic [15:0] cx, cy, sw, sh, sc, logic lst);
      longint x1, y1, x2, y2, lcx, lcy, lsw, lsh;
      box_t    nb;
      bit      gone[STORE_DEPTH];
      bit      drop;
      int      pos;
      result_t r;
      boxes++;
      lcx = cx;
      lcy = cy;
      lsw = sw;
      lsh = sh;
      if (sc >= conf) begin
        x1 = map_edge(2 * lcx - lsw - 32 * longint'(padl), imw);
        y1 = map_edge(2 * lcy - lsh - 32 * longint'(padt), imh);
        x2 = map_edge(2 * lcx + lsw - 32 * longint'(padl), imw);
        y2 = map_edge(2 * lcy + lsh - 32 * longint'(padt), imh);
        nb.x = 12'(x1);
        nb.y = 12'(y1);
        nb.w = 12'(x2 - x1);
        nb.h = 12'(y2 - y1);
        nb.score = sc;
        drop = 0;
        if (cnt >= STORE_DEPTH) begin
          if (nb.score <= store[STORE_DEPTH-1].score) drop = 1;
          else cnt = STORE_DEPTH - 1;
        end
        if (!drop) begin
          pos = 0;
          while (pos < cnt && store[pos].score >= nb.score) pos++;
          for (int k = cnt; k > pos; k--) store[k] = store[k-1];
          store[pos] = nb;
          cnt++;
        end
      end
      if (!lst) return;
      frames++;
      if (cnt == 0) begin
        r.b = '0;
        r.lst = 1;
        r.none = 1;
        expq = {expq, r};
        return;
      end
      foreach (gone[k]) gone[k] = 0;
      for (int i = 0; i < cnt; i++) begin
        if (gone[i]) continue;
        for (int j = i + 1; j < cnt; j++)
          if (!gone[j] && overlaps(store[i], store[j])) gone[j] = 1;
      end
      for (int i = 0; i < cnt; i++) begin
        if (gone[i]) continue;
        r.b = store[i];
        r.lst = 0;
        r.none = 0;
        expq = {expq, r};
      end
      expq[expq.size()-1].lst = 1;
      cnt = 0;
    endfunction

    // Compare one accepted result word with the oldest expectation
    function void check_result(logic [OUT_DATA_W-1:0] d, logic l, logic u);
      result_t e;
      box_t    got;
      results++;
      if (expq.size() == 0) begin
        $error("unexpected result word %h last=%b none=%b", d, l, u);
        errors++;
        return;
      end
      e = expq.pop_front();
      got = d;
      if (got.x !== e.b.x) begin
        $error("left: expected %0d, got %0d", e.b.x, got.x); errors++;
      end
      if (got.y !== e.b.y) begin
        $error("top: expected %0d, got %0d", e.b.y, got.y); errors++;
      end
      if (got.w !== e.b.w) begin
        $error("box_width: expected %0d, got %0d", e.b.w, got.w); errors++;
      end
      if (got.h !== e.b.h) begin
        $error("box_height: expected %0d, got %0d", e.b.h, got.h); errors++;
      end
      if (got.score !== e.b.score) begin
        $error("kept_score: expected %0d, got %0d", e.b.score, got.score); errors++;
      end
      if (l !== e.lst) begin
        $error("last_result: expected %0d, got %0d", e.lst, l); errors++;
      end
      if (u !== e.none) begin
        $error("none_found: expected %0d, got %0d", e.none, u); errors++;
      end
    endfunction
  endclass

  logic                  clk = 0;
  logic                  rst_n = 0;
  logic                  cfg_valid = 0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_tvalid = 0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  in_tlast = 0;
  logic                  out_tvalid;
  logic                  out_tready = 0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tlast;
  logic                  out_tuser;

  nms_scoreboard sb = new();
  bit            calm = 0;
  longint        cycles = 0;
  int            settings = 1;
  int            base_x, base_y;

  box_filter_nms uut (.*);

  always #5 clk = ~clk;

  // Stall the result side at random, except in calm stretches
  always @(posedge clk) out_tready <= calm || ($urandom_range(99) >= 23);

  // Check results where they are stable, ahead of the accepting edge
  always @(negedge clk)
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata, out_tlast, out_tuser);

  // Cycle limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [15:0] v);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= v;
    do @(negedge clk); while (!cfg_ready);
    @(posedge clk);
    sb.set_reg(idx, v);
    cfg_valid <= 0;
    @(posedge clk);
  endtask

  task automatic write_all(logic [15:0] c, o, w, h, s, pl, pt);
    cfg_write(REG_CONF, c);
    cfg_write(REG_OVL, o);
    cfg_write(REG_IMW, w);
    cfg_write(REG_IMH, h);
    cfg_write(REG_SCL, s);
    cfg_write(REG_PADL, pl);
    cfg_write(REG_PADT, pt);
    settings++;
  endtask

  // Send one box word, at times after a random gap (never in calm stretches)
  task automatic send_box(logic [15:0] cx, cy, sw, sh, sc, logic lst);
    if (!calm && $urandom_range(99) < 23) begin
      in_tvalid <= 0;
      do @(posedge clk); while ($urandom_range(99) < 23);
    end
    in_tvalid <= 1;
    in_tdata <= {sc, sh, sw, cy, cx};
    in_tlast <= lst;
    do @(negedge clk); while (!in_tready);
    @(posedge clk);
    sb.note_box(cx, cy, sw, sh, sc, lst);
  endtask

  // Drop valid and hold until every expected result is out, then let the block settle
  task automatic drain;
    in_tvalid <= 0;
    while (sb.expq.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  function automatic logic [15:0] near(int b);
    int v;
    v = b + int'($urandom_range(512)) - 256;
    return (v < 0) ? 16'd0 : (v > 65535) ? 16'hFFFF : v[15:0];
  endfunction

  // One box of the current cluster, a tie score, or pure noise
  task automatic send_random(logic lst);
    logic [15:0] sc;
    case ($urandom_range(5))
      0: send_box(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                  16'($urandom), lst);
      1: begin
        sc = 16'(30000 + 10000 * $urandom_range(2));
        send_box(near(base_x), near(base_y), 16'($urandom_range(64, 4000)),
                 16'($urandom_range(64, 4000)), sc, lst);
      end
      default: send_box(near(base_x), near(base_y), 16'($urandom_range(64, 4000)),
                        16'($urandom_range(64, 4000)), 16'($urandom), lst);
    endcase
  endtask

  task automatic random_frames(int n_items);
    int left_items, len;
    left_items = n_items;
    while (left_items > 0) begin
      len = $urandom_range(1, 8);
      base_x = $urandom_range(16000);
      base_y = $urandom_range(16000);
      for (int k = 0; k < len; k++) send_random(k == len - 1);
      left_items -= len;
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed: empty frame, then extremes, threshold edge, ties and zero area
    send_box(16'd100, 16'd100, 16'd50, 16'd50, 16'd0, 1);
    send_box(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 0);
    send_box(16'd0, 16'd0, 16'd0, 16'd0, 16'd16384, 0);
    send_box(16'd3200, 16'd3200, 16'd640, 16'd640, 16'd16383, 0);
    send_box(16'd4000, 16'd4000, 16'd800, 16'd800, 16'd50000, 0);
    send_box(16'd4000, 16'd4000, 16'd800, 16'd800, 16'd50000, 0);
    send_box(16'd4010, 16'd4020, 16'd780, 16'd820, 16'd49000, 0);
    send_box(16'd6000, 16'd6000, 16'd0, 16'd0, 16'd40000, 0);
    send_box(16'd6000, 16'd6000, 16'd0, 16'd0, 16'd40000, 1);
    drain();

    // Scale zero, image dimensions zero and oversize, ignored index
    write_all(16'd8000, 16'd20000, 16'd0, 16'd8191, 16'd0, 16'd3, 16'd7);
    cfg_write(REG_NONE, 16'hFFFF);
    send_box(16'd200, 16'd300, 16'd40, 16'd40, 16'd9000, 0);
    send_box(16'd65535, 16'd65535, 16'd65535, 16'd1, 16'd9000, 1);
    drain();

    // Low extremes: keep everything, any overlap suppresses, big scale
    write_all(16'd0, 16'd0, 16'd4096, 16'd4096, 16'hFFFF, 16'd0, 16'd0);
    random_frames(8);
    drain();

    // High extremes: tiny image, maximal padding, unit scale
    write_all(16'hFFFF, 16'hFFFF, 16'd1, 16'd1, 16'd1, 16'd4095, 16'd4095);
    send_box(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 0);
    send_box(16'd0, 16'd0, 16'd0, 16'd0, 16'hFFFE, 1);
    random_frames(4);
    drain();

    // Typical settings; one stretch without stalls
    for (int p = 0; p < 3; p++) begin
      write_all(16'($urandom_range(40000)), 16'($urandom), 16'($urandom_range(1, 4096)),
                16'($urandom_range(1, 4096)), 16'($urandom_range(8192, 32768)),
                16'($urandom_range(200)), 16'($urandom_range(200)));
      calm = (p == 1);
      random_frames(6);
      drain();
    end
    calm = 0;

    // Overfill the store so the lowest scores fall out
    write_all(16'd0, 16'd29491, 16'd4096, 16'd4096, 16'd16384, 16'd0, 16'd0);
    for (int k = 0; k < 66; k++)
      send_box(16'($urandom), 16'($urandom), 16'($urandom_range(64, 2000)),
               16'($urandom_range(64, 2000)), 16'($urandom), k == 65);
    drain();

    $display("Run covered %0d frames of %0d boxes, %0d result words, %0d register settings",
             sb.frames, sb.boxes, sb.results, settings);
    if (sb.expq.size() != 0) sb.errors++;
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
